// ===== rtl/core/rmpu_pkg.sv =====
// rmpu_pkg: shared types and constants of the region map protection unit
// used by rmpu_table and region_map_protection_unit; no dependencies
package rmpu_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  localparam int PERM_READ_BIT  = 0;
  localparam int PERM_WRITE_BIT = 1;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_RAW   = 2'd1,
    OP_LOAD  = 2'd2,
    OP_STORE = 2'd3
  } op_t;

  // one table entry; the end address is kept instead of the length
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] rend;
    logic [63:0] backing;
    logic [1:0]  perms;
  } region_t;

endpackage

// ===== rtl/core/rmpu_table.sv =====
// rmpu_table: region table memory, one write and one registered read per cycle
// depends on rmpu_pkg
module rmpu_table (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rmpu_pkg::IDX_W-1:0] wr_idx,
  input  rmpu_pkg::region_t          wr_entry,
  input  logic [rmpu_pkg::IDX_W-1:0] rd_idx,
  output rmpu_pkg::region_t          rd_entry
);

  rmpu_pkg::region_t mem [rmpu_pkg::MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry <= mem[rd_idx];
  end

endmodule

// ===== rtl/core/region_map_protection_unit.sv =====
// region_map_protection_unit: top level, sequencer, fault latch and response register
// depends on rmpu_pkg and rmpu_table
//
// usage:
//   request channel req_valid/req_ready carries operation, address, access_size,
//   backing_base, perms and write_flag. operation map adds a region; raw access,
//   load and store look up the region holding the address and translate it.
//   response channel rsp_valid/rsp_ready carries ok, backing_address, the fault
//   latch (is_faulted, fault_addr, fault_length, fault_was_write) and
//   region_count. one response per request, in order.
//   timing: a request is taken in the idle state, checked in the pre-check step,
//   then the table is walked one entry a cycle through the single registered
//   read port, visiting at most MAX_REGIONS entries; a hit then passes through
//   the translation step before the finish step.
//   req_ready is high only while the sequencer is idle; a new request may be
//   taken while the previous response still waits in the output register.
//   if the receiver stalls, the finished item holds in its last step until the
//   output register frees up.
//   reset clears the region count, the fault latch and both channels; table
//   contents are not cleared since only entries below the count are read.
module region_map_protection_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] address,
  input  logic [31:0] access_size,
  input  logic [63:0] backing_base,
  input  logic [3:0]  perms,
  input  logic        write_flag,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        ok,
  output logic [63:0] backing_address,
  output logic        is_faulted,
  output logic [63:0] fault_addr,
  output logic [31:0] fault_length,
  output logic        fault_was_write,
  output logic [4:0]  region_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_SCAN,
    S_XLAT,
    S_FIN
  } state_t;

  state_t                      state;
  rmpu_pkg::op_t               item_op;
  logic [63:0]                 item_addr;
  logic [31:0]                 item_len;
  logic [63:0]                 item_backing;
  logic [3:0]                  item_perms;
  logic                        item_wr;
  logic [63:0]                 item_end;
  logic [rmpu_pkg::IDX_W-1:0]  idx;
  logic [rmpu_pkg::CNT_W-1:0]  count;
  logic                        res_ok;
  logic                        res_fault;
  logic                        res_map;
  logic [63:0]                 hit_base;
  logic [63:0]                 hit_backing;
  logic [63:0]                 xlat_off;
  logic                        fault_flag;
  logic [63:0]                 saved_fault_addr;
  logic [31:0]                 saved_fault_length;
  logic                        saved_fault_write;

  logic [64:0]                 pre_sum;
  logic                        scalar_ok;
  logic                        map_bad;
  logic                        access_bad;
  logic                        below_end;
  logic                        hit;
  logic                        overlap;
  logic                        span_ok;
  logic                        perm_ok;
  logic                        last;
  logic                        out_free;
  logic [63:0]                 fin_sum;
  logic                        tbl_wr_en;
  logic [rmpu_pkg::IDX_W-1:0]  rd_idx;
  rmpu_pkg::region_t           wr_entry;
  rmpu_pkg::region_t           rd_entry;

  always_comb begin
    pre_sum   = {1'b0, item_addr} + {33'b0, item_len};
    scalar_ok = item_len inside {32'd1, 32'd2, 32'd4, 32'd8};
    map_bad   = (item_backing == 64'd0) || (item_len == 32'd0) ||
                (item_perms[1:0] == 2'b00) || (item_perms[3:2] != 2'b00) ||
                (count >= rmpu_pkg::CNT_W'(rmpu_pkg::MAX_REGIONS)) || pre_sum[64];
    access_bad = ((item_op != rmpu_pkg::OP_RAW) && !scalar_ok) ||
                 (item_len == 32'd0) || pre_sum[64] ||
                 (count == rmpu_pkg::CNT_W'(0));
    below_end = item_addr < rd_entry.rend;
    hit       = (rd_entry.base <= item_addr) && below_end;
    overlap   = below_end && (rd_entry.base < item_end);
    span_ok   = item_end <= rd_entry.rend;
    perm_ok   = item_wr ? rd_entry.perms[rmpu_pkg::PERM_WRITE_BIT]
                        : rd_entry.perms[rmpu_pkg::PERM_READ_BIT];
    last      = (rmpu_pkg::CNT_W'(idx) + rmpu_pkg::CNT_W'(1)) == count;
    out_free  = !rsp_valid || rsp_ready;
    fin_sum   = hit_backing + xlat_off;
    // read address runs one entry ahead of the compare
    rd_idx    = (state == S_PRE) ? '0 : idx + rmpu_pkg::IDX_W'(1);
    tbl_wr_en = (state == S_FIN) && out_free && res_map;
    wr_entry  = '{base: item_addr, rend: item_end, backing: item_backing,
                  perms: item_perms[1:0]};
  end

  assign req_ready = (state == S_IDLE);

  rmpu_table u_table (
    .clk      (clk),
    .wr_en    (tbl_wr_en),
    .wr_idx   (count[rmpu_pkg::IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      rsp_valid          <= 1'b0;
      count              <= '0;
      fault_flag         <= 1'b0;
      saved_fault_addr   <= '0;
      saved_fault_length <= '0;
      saved_fault_write  <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (rsp_valid && rsp_ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item_op      <= rmpu_pkg::op_t'(operation);
            item_addr    <= address;
            item_len     <= access_size;
            item_backing <= backing_base;
            item_perms   <= perms;
            item_wr      <= (operation == rmpu_pkg::OP_STORE) ||
                            ((operation == rmpu_pkg::OP_RAW) && write_flag);
            state        <= S_PRE;
          end
        end
        S_PRE: begin
          item_end  <= pre_sum[63:0];
          idx       <= '0;
          res_ok    <= 1'b0;
          res_fault <= 1'b0;
          res_map   <= 1'b0;
          if (fault_flag) begin
            state <= S_FIN;
          end else if (item_op == rmpu_pkg::OP_MAP) begin
            if (map_bad) begin
              state <= S_FIN;
            end else if (count == rmpu_pkg::CNT_W'(0)) begin
              res_ok  <= 1'b1;
              res_map <= 1'b1;
              state   <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end else if (access_bad) begin
            res_fault <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (item_op == rmpu_pkg::OP_MAP) begin
            if (overlap) begin
              state <= S_FIN;
            end else if (last) begin
              res_ok  <= 1'b1;
              res_map <= 1'b1;
              state   <= S_FIN;
            end else begin
              idx <= idx + rmpu_pkg::IDX_W'(1);
            end
          end else if (hit) begin
            // first containing region decides, later ones are not searched
            if (span_ok && perm_ok) begin
              hit_base    <= rd_entry.base;
              hit_backing <= rd_entry.backing;
              state       <= S_XLAT;
            end else begin
              res_fault <= 1'b1;
              state     <= S_FIN;
            end
          end else if (last) begin
            res_fault <= 1'b1;
            state     <= S_FIN;
          end else begin
            idx <= idx + rmpu_pkg::IDX_W'(1);
          end
        end
        S_XLAT: begin
          xlat_off <= item_addr - hit_base;
          res_ok   <= 1'b1;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp_valid       <= 1'b1;
            ok              <= res_ok;
            backing_address <= (res_ok && !res_map) ? fin_sum : 64'd0;
            is_faulted      <= fault_flag || res_fault;
            if (res_fault) begin
              fault_flag         <= 1'b1;
              saved_fault_addr   <= item_addr;
              saved_fault_length <= item_len;
              saved_fault_write  <= item_wr;
              fault_addr         <= item_addr;
              fault_length       <= item_len;
              fault_was_write    <= item_wr;
            end else begin
              fault_addr         <= saved_fault_addr;
              fault_length       <= saved_fault_length;
              fault_was_write    <= saved_fault_write;
            end
            if (res_map) begin
              count        <= count + rmpu_pkg::CNT_W'(1);
              region_count <= 5'(count + rmpu_pkg::CNT_W'(1));
            end else begin
              region_count <= 5'(count);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fault_sticks: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("fault latch cleared outside reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rmpu_pkg::CNT_W'(rmpu_pkg::MAX_REGIONS))
    else $error("region count beyond table depth");

  a_map_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free && res_map) |=> count == $past(count) + rmpu_pkg::CNT_W'(1))
    else $error("accepted map did not grow the table");

  a_ok_xor_fault: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> !(res_ok && res_fault))
    else $error("item both succeeded and faulted");

  a_faulted_refuses: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && is_faulted) |-> !ok)
    else $error("success reported while faulted");
`endif

endmodule
